// File: rtl/stack_queue_trace_classifier_assert.svh
// Assertion macros shared by the RTL files.
`ifndef STACK_QUEUE_TRACE_CLASSIFIER_ASSERT_SVH
`define STACK_QUEUE_TRACE_CLASSIFIER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Check that a property holds at every clock edge outside reset.
`define SQTC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that a trigger implies an outcome in the next cycle.
`define SQTC_ASSERT_NEXT(label, clk, rst, trig, outcome, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (outcome)) else $error(msg);
`else
`define SQTC_ASSERT(label, clk, rst, prop, msg)
`define SQTC_ASSERT_NEXT(label, clk, rst, trig, outcome, msg)
`endif

`endif

// File: rtl/sqtc_pkg.sv
package sqtc_pkg;

   localparam int KEY_W       = 32;
   localparam int OP_W        = 2;
   localparam int VERDICT_W   = 3;
   localparam int RSP_DATA_W  = 8;
   localparam int STORE_DEPTH = 256;

   // Operation codes carried on the request tuser
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;

   typedef enum logic [VERDICT_W-1:0] {
      VERDICT_BOTH     = 3'd0,
      VERDICT_QUEUE    = 3'd1,
      VERDICT_STACK    = 3'd2,
      VERDICT_NEITHER  = 3'd3,
      VERDICT_OVERFLOW = 3'd4
   } verdict_type;

   // Per-cycle command broadcast to every cell
   typedef struct packed {
      logic push;
      logic pop_stack;
      logic pop_queue;
      logic clear;
   } cell_ctl_type;

   // Status seen at the ends of the chain
   typedef struct packed {
      logic stack_top_valid;
      logic stack_full;
      logic queue_head_valid;
      logic queue_full;
   } chain_status_type;

endpackage

// File: rtl/sqtc_cell.sv
module sqtc_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  sqtc_pkg::cell_ctl_type           ctl,
   input  logic signed [sqtc_pkg::KEY_W-1:0] key,
   // stack neighbors: prev is nearer the top, next is deeper
   input  logic signed [sqtc_pkg::KEY_W-1:0] prev_s_data,
   input  logic                             prev_s_valid,
   input  logic signed [sqtc_pkg::KEY_W-1:0] next_s_data,
   input  logic                             next_s_valid,
   // queue neighbors: prev is nearer the head, next is nearer the tail
   input  logic                             prev_q_valid,
   input  logic signed [sqtc_pkg::KEY_W-1:0] next_q_data,
   input  logic                             next_q_valid,
   output logic signed [sqtc_pkg::KEY_W-1:0] s_data,
   output logic                             s_valid,
   output logic signed [sqtc_pkg::KEY_W-1:0] q_data,
   output logic                             q_valid
);

   logic signed [sqtc_pkg::KEY_W-1:0] s_data_ff, s_data_in;
   logic                              s_valid_ff, s_valid_in;
   logic signed [sqtc_pkg::KEY_W-1:0] q_data_ff, q_data_in;
   logic                              q_valid_ff, q_valid_in;

   // Stack slot: shift down on push, up on pop, empty on clear
   always_comb begin
      s_data_in  = s_data_ff;
      s_valid_in = s_valid_ff;
      if (ctl.clear) begin
         s_valid_in = 1'b0;
      end else if (ctl.push) begin
         s_data_in  = prev_s_data;
         s_valid_in = prev_s_valid;
      end else if (ctl.pop_stack) begin
         s_data_in  = next_s_data;
         s_valid_in = next_s_valid;
      end
   end

   // Queue slot: first empty slot takes the key, shift toward head on pop, empty on clear
   always_comb begin
      q_data_in  = q_data_ff;
      q_valid_in = q_valid_ff;
      if (ctl.clear) begin
         q_valid_in = 1'b0;
      end else if (ctl.push) begin
         if (!q_valid_ff && prev_q_valid) begin
            q_data_in  = key;
            q_valid_in = 1'b1;
         end
      end else if (ctl.pop_queue) begin
         q_data_in  = next_q_data;
         q_valid_in = next_q_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
         q_valid_ff <= 1'b0;
      end else begin
         s_valid_ff <= s_valid_in;
         q_valid_ff <= q_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s_data_ff <= s_data_in;
      q_data_ff <= q_data_in;
   end

   assign s_data  = s_data_ff;
   assign s_valid = s_valid_ff;
   assign q_data  = q_data_ff;
   assign q_valid = q_valid_ff;

endmodule

// File: rtl/sqtc_chain.sv
`include "stack_queue_trace_classifier_assert.svh"

module sqtc_chain #(
   parameter int STORE_DEPTH = sqtc_pkg::STORE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  sqtc_pkg::cell_ctl_type            ctl,
   input  logic signed [sqtc_pkg::KEY_W-1:0] key,
   output logic signed [sqtc_pkg::KEY_W-1:0] stack_top,
   output logic signed [sqtc_pkg::KEY_W-1:0] queue_front,
   output sqtc_pkg::chain_status_type        status
);

   logic signed [sqtc_pkg::KEY_W-1:0] s_data  [STORE_DEPTH];
   logic                              s_valid [STORE_DEPTH];
   logic signed [sqtc_pkg::KEY_W-1:0] q_data  [STORE_DEPTH];
   logic                              q_valid [STORE_DEPTH];

   // Row of cells, cell 0 is stack top and queue head
   for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
      logic signed [sqtc_pkg::KEY_W-1:0] prev_s_data;
      logic                              prev_s_valid;
      logic signed [sqtc_pkg::KEY_W-1:0] next_s_data;
      logic                              next_s_valid;
      logic                              prev_q_valid;
      logic signed [sqtc_pkg::KEY_W-1:0] next_q_data;
      logic                              next_q_valid;

      if (i == 0) begin : g_first
         assign prev_s_data  = key;
         assign prev_s_valid = 1'b1;
         assign prev_q_valid = 1'b1;
      end else begin : g_mid
         assign prev_s_data  = s_data[i-1];
         assign prev_s_valid = s_valid[i-1];
         assign prev_q_valid = q_valid[i-1];
      end

      if (i == STORE_DEPTH-1) begin : g_last
         assign next_s_data  = '0;
         assign next_s_valid = 1'b0;
         assign next_q_data  = '0;
         assign next_q_valid = 1'b0;
      end else begin : g_inner
         assign next_s_data  = s_data[i+1];
         assign next_s_valid = s_valid[i+1];
         assign next_q_data  = q_data[i+1];
         assign next_q_valid = q_valid[i+1];
      end

      sqtc_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctl          (ctl),
         .key          (key),
         .prev_s_data  (prev_s_data),
         .prev_s_valid (prev_s_valid),
         .next_s_data  (next_s_data),
         .next_s_valid (next_s_valid),
         .prev_q_valid (prev_q_valid),
         .next_q_data  (next_q_data),
         .next_q_valid (next_q_valid),
         .s_data       (s_data[i]),
         .s_valid      (s_valid[i]),
         .q_data       (q_data[i]),
         .q_valid      (q_valid[i])
      );
   end

   // Report the ends of the row
   assign stack_top                 = s_data[0];
   assign queue_front               = q_data[0];
   assign status.stack_top_valid    = s_valid[0];
   assign status.stack_full         = s_valid[STORE_DEPTH-1];
   assign status.queue_head_valid   = q_valid[0];
   assign status.queue_full         = q_valid[STORE_DEPTH-1];

   // Occupied slots stay packed toward the head of each row
   for (genvar j = 1; j < STORE_DEPTH; j++) begin : g_check
      `SQTC_ASSERT(a_stack_packed, clock, reset, !s_valid[j] || s_valid[j-1], "stack hole")
      `SQTC_ASSERT(a_queue_packed, clock, reset, !q_valid[j] || q_valid[j-1], "queue hole")
   end

endmodule

// File: rtl/stack_queue_trace_classifier.sv
// Stack/queue trace classifier. Insert and remove operations arrive one per transfer on
// req_ (key in tdata, operation in tuser, end of batch in tlast); one operation is taken every
// clock cycle. The stack and the queue are mirrored in a row of STORE_DEPTH cells that shift
// by one slot per operation, so the fill never slows the operation rate. On the
// transfer with tlast set the verdict (0 both, 1 queue only, 2 stack only, 3 neither,
// 4 overflow) is registered and offered on rsp_ in the next cycle, and all state returns to
// empty in that same cycle, with no clearing pass. The request side stalls only while a
// verdict waits for rsp_tready.
`include "stack_queue_trace_classifier_assert.svh"

module stack_queue_trace_classifier #(
   parameter int STORE_DEPTH = sqtc_pkg::STORE_DEPTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic signed [sqtc_pkg::KEY_W-1:0]      req_tdata,  // [31:0] key
   input  logic        [sqtc_pkg::OP_W-1:0]       req_tuser,  // [1:0] req_type
   input  logic                                   req_tlast,  // last_command
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic        [sqtc_pkg::RSP_DATA_W-1:0] rsp_tdata   // [2:0] verdict, [7:3] zero
);

   logic                              req_fire;
   logic                              is_insert;
   logic                              is_remove;
   logic                              stack_match;
   logic                              queue_match;
   logic                              any_full;
   logic                              stack_ok_now;
   logic                              queue_ok_now;
   logic                              overflow_now;
   logic signed [sqtc_pkg::KEY_W-1:0] stack_top;
   logic signed [sqtc_pkg::KEY_W-1:0] queue_front;
   sqtc_pkg::chain_status_type        status;
   sqtc_pkg::cell_ctl_type            ctl;
   sqtc_pkg::verdict_type             verdict;

   logic                  stack_ok_ff, stack_ok_in;
   logic                  queue_ok_ff, queue_ok_in;
   logic                  overflowed_ff, overflowed_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   sqtc_pkg::verdict_type verdict_ff, verdict_in;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign is_insert  = (req_tuser == sqtc_pkg::OP_INSERT);
   assign is_remove  = (req_tuser == sqtc_pkg::OP_REMOVE);

   // Compare the key against both ends of the row
   assign stack_match = status.stack_top_valid && (stack_top == req_tdata);
   assign queue_match = status.queue_head_valid && (queue_front == req_tdata);
   assign any_full    = status.stack_full || status.queue_full;

   // Drive the cell row
   always_comb begin
      ctl.push      = req_fire && is_insert && !any_full;
      ctl.pop_stack = req_fire && is_remove && stack_match;
      ctl.pop_queue = req_fire && is_remove && queue_match;
      ctl.clear     = req_fire && req_tlast;
   end

   // Flags including this operation
   assign stack_ok_now = stack_ok_ff && !(is_remove && !stack_match);
   assign queue_ok_now = queue_ok_ff && !(is_remove && !queue_match);
   assign overflow_now = overflowed_ff || (is_insert && any_full);

   // Pick the verdict, overflow first
   always_comb begin
      if (overflow_now) begin
         verdict = sqtc_pkg::VERDICT_OVERFLOW;
      end else if (queue_ok_now && stack_ok_now) begin
         verdict = sqtc_pkg::VERDICT_BOTH;
      end else if (queue_ok_now) begin
         verdict = sqtc_pkg::VERDICT_QUEUE;
      end else if (stack_ok_now) begin
         verdict = sqtc_pkg::VERDICT_STACK;
      end else begin
         verdict = sqtc_pkg::VERDICT_NEITHER;
      end
   end

   // Update sticky flags, rearm at end of batch
   always_comb begin
      stack_ok_in   = stack_ok_ff;
      queue_ok_in   = queue_ok_ff;
      overflowed_in = overflowed_ff;
      if (req_fire) begin
         if (req_tlast) begin
            stack_ok_in   = 1'b1;
            queue_ok_in   = 1'b1;
            overflowed_in = 1'b0;
         end else begin
            stack_ok_in   = stack_ok_now;
            queue_ok_in   = queue_ok_now;
            overflowed_in = overflow_now;
         end
      end
   end

   // Hold the verdict until its transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      verdict_in   = verdict_ff;
      if (req_fire && req_tlast) begin
         rsp_valid_in = 1'b1;
         verdict_in   = verdict;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stack_ok_ff   <= 1'b1;
         queue_ok_ff   <= 1'b1;
         overflowed_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         stack_ok_ff   <= stack_ok_in;
         queue_ok_ff   <= queue_ok_in;
         overflowed_ff <= overflowed_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      verdict_ff <= verdict_in;
   end

   sqtc_chain #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_chain (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .key         (req_tdata),
      .stack_top   (stack_top),
      .queue_front (queue_front),
      .status      (status)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(sqtc_pkg::RSP_DATA_W - sqtc_pkg::VERDICT_W){1'b0}}, verdict_ff};

   // End of batch empties both mirrors and rearms the flags
   `SQTC_ASSERT_NEXT(a_batch_clear, clock, reset, req_fire && req_tlast, !status.stack_top_valid && !status.queue_head_valid && stack_ok_ff && queue_ok_ff && !overflowed_ff, "state not cleared after batch")
   // A new verdict appears only after a last transfer
   `SQTC_ASSERT(a_rsp_source, clock, reset, !$rose(rsp_valid_ff) || $past(req_fire && req_tlast), "verdict without batch end")
   // An insert into full mirrors changes neither mirror
   `SQTC_ASSERT_NEXT(a_full_drop, clock, reset, req_fire && is_insert && any_full && !req_tlast, overflowed_ff && $stable(status), "insert into full mirrors changed state")

endmodule

// File: test/stack_queue_trace_classifier_checker.sv
module stack_queue_trace_classifier_checker
   import sqtc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [KEY_W-1:0]      req_tdata,  // [31:0] key
   input  logic [OP_W-1:0]       req_tuser,  // [1:0] req_type
   input  logic                  req_tlast,  // last_command
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,  // [2:0] verdict, [7:3] zero
   output int                    mismatch_count,
   output int                    verdicts_outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   // Mirrors of the trace seen so far in the current batch
   logic [KEY_W-1:0] stack_keys [STORE_DEPTH];
   logic [KEY_W-1:0] queue_keys [STORE_DEPTH];
   int               stack_fill;
   int               queue_head_idx;
   int               queue_tail_idx;
   int               queue_fill;
   bit               stack_fits;
   bit               queue_fits;
   bit               overflow_seen;

   // Verdicts owed by the block, oldest first
   verdict_type      expected_verdicts [$];

   initial begin
      mismatch_count       = 0;
      verdicts_outstanding = 0;
   end

   task automatic report_mismatch(input string what);
      $display("%0t: verdict mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic clear_trace();
      stack_fill     = 0;
      queue_head_idx = 0;
      queue_tail_idx = 0;
      queue_fill     = 0;
      stack_fits     = 1'b1;
      queue_fits     = 1'b1;
      overflow_seen  = 1'b0;
   endtask

   // Apply one operation to both mirrors; close the batch on its last operation
   task automatic track_operation(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                                  input logic last_op);
      verdict_type closing;
      case (op)
         OP_INSERT: begin
            if (stack_fill >= STORE_DEPTH || queue_fill >= STORE_DEPTH) begin
               overflow_seen = 1'b1;
            end else begin
               stack_keys[stack_fill] = key;
               stack_fill++;
               queue_keys[queue_tail_idx] = key;
               queue_tail_idx = (queue_tail_idx + 1) % STORE_DEPTH;
               queue_fill++;
            end
         end
         OP_REMOVE: begin
            // a mirror pops only when its end matches the key
            if (stack_fill == 0 || stack_keys[stack_fill-1] != key) begin
               stack_fits = 1'b0;
            end else begin
               stack_fill--;
            end
            if (queue_fill == 0 || queue_keys[queue_head_idx] != key) begin
               queue_fits = 1'b0;
            end else begin
               queue_head_idx = (queue_head_idx + 1) % STORE_DEPTH;
               queue_fill--;
            end
         end
         default: ;
      endcase
      if (last_op) begin
         if (overflow_seen)
            closing = VERDICT_OVERFLOW;
         else if (queue_fits && stack_fits)
            closing = VERDICT_BOTH;
         else if (queue_fits)
            closing = VERDICT_QUEUE;
         else if (stack_fits)
            closing = VERDICT_STACK;
         else
            closing = VERDICT_NEITHER;
         expected_verdicts.push_back(closing);
         clear_trace();
      end
   endtask

   // Compare each verdict transfer, then track each request transfer
   always @(posedge clock) begin
      verdict_type oldest;
      if (reset) begin
         clear_trace();
         expected_verdicts.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_verdicts.size() == 0) begin
               report_mismatch($sformatf("verdict 0x%0h with none outstanding", rsp_tdata));
            end else begin
               oldest = expected_verdicts.pop_front();
               if (rsp_tdata !== RSP_DATA_W'(oldest))
                  report_mismatch($sformatf("got 0x%0h, expected %0d (%s)",
                                            rsp_tdata, oldest, oldest.name()));
            end
         end
         if (req_tvalid && req_tready)
            track_operation(req_tuser, req_tdata, req_tlast);
      end
      verdicts_outstanding <= expected_verdicts.size();
   end

endmodule

// File: test/tb_stack_queue_trace_classifier.sv
module tb_stack_queue_trace_classifier
   import sqtc_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int              CYCLE_LIMIT = 300000;
   localparam int              TARGET_OPS  = 1900;
   localparam logic [OP_W-1:0] OP_ODD_LO   = 2'd2;
   localparam logic [OP_W-1:0] OP_ODD_HI   = 2'd3;

   typedef enum int {
      FOLLOW_STACK,
      FOLLOW_QUEUE,
      FOLLOW_EITHER
   } remove_policy_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [KEY_W-1:0]      req_tdata  = '0;  // [31:0] key
   logic [OP_W-1:0]       req_tuser  = '0;  // [1:0] req_type
   logic                  req_tlast  = 1'b0;  // last_command
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;  // [2:0] verdict, [7:3] zero

   int                    mismatch_count;
   int                    verdicts_outstanding;
   int                    cycle_count = 0;
   int                    ops_sent    = 0;
   bit                    steady_flow = 1'b0;

   always #2 clock = ~clock;

   stack_queue_trace_classifier i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   stack_queue_trace_classifier_checker i_checker (
      .clock                (clock),
      .reset                (reset),
      .req_tvalid           (req_tvalid),
      .req_tready           (req_tready),
      .req_tdata            (req_tdata),
      .req_tuser            (req_tuser),
      .req_tlast            (req_tlast),
      .rsp_tvalid           (rsp_tvalid),
      .rsp_tready           (rsp_tready),
      .rsp_tdata            (rsp_tdata),
      .mismatch_count       (mismatch_count),
      .verdicts_outstanding (verdicts_outstanding)
   );

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Stall the verdict channel at random before each transfer, except in steady flow
   initial begin
      int hold_cycles;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         hold_cycles = steady_flow ? 0 : $urandom_range(0, 18);
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Keys from a pool of up to eight fixed values so that keys repeat; pool 0 draws any key
   function automatic logic [KEY_W-1:0] pick_key(input int pool);
      if (pool == 0)
         return $urandom;
      case ($urandom_range(0, pool - 1))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h8000_0000;
         3:       return 32'h7FFF_FFFF;
         4:       return 32'h0000_0001;
         5:       return 32'h0000_0002;
         6:       return 32'h5555_5555;
         default: return 32'hAAAA_AAAA;
      endcase
   endfunction

   // Offer one operation after a random gap and hold it until the transfer
   task automatic send_op(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                          input logic last_op);
      int gap_cycles;
      gap_cycles = steady_flow ? 0 : $urandom_range(0, 18);
      if (gap_cycles > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap_cycles) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= key;
      req_tuser  <= op;
      req_tlast  <= last_op;
      do @(posedge clock); while (!req_tready);
      if (op == OP_INSERT || op == OP_REMOVE)
         ops_sent++;
   endtask

   // Stop offering and wait until every verdict has been taken
   task automatic drain_verdicts();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (verdicts_outstanding != 0) @(posedge clock);
   endtask

   // Random batch whose removes mostly follow the chosen discipline
   task automatic run_batch(input int len, input remove_policy_type policy, input int pool);
      logic [KEY_W-1:0] live [$];
      logic [KEY_W-1:0] key;
      logic [OP_W-1:0]  op;
      int               choice;
      for (int n = 0; n < len; n++) begin
         choice = $urandom_range(0, 99);
         if (choice < 5) begin
            op  = $urandom_range(0, 1) ? OP_ODD_HI : OP_ODD_LO;
            key = $urandom;
         end else if ((live.size() == 0 && choice < 90) || (live.size() != 0 && choice < 52)) begin
            op  = OP_INSERT;
            key = pick_key(pool);
            live.push_back(key);
         end else begin
            op = OP_REMOVE;
            if (live.size() == 0 || $urandom_range(0, 49) == 0) begin
               key = pick_key(pool);
            end else begin
               case (policy)
                  FOLLOW_STACK: key = live.pop_back();
                  FOLLOW_QUEUE: key = live.pop_front();
                  default: begin
                     choice = $urandom_range(0, 9);
                     if (choice < 4)
                        key = live.pop_back();
                     else if (choice < 8)
                        key = live.pop_front();
                     else
                        key = pick_key(pool);
                  end
               endcase
            end
         end
         send_op(op, key, n == len - 1);
      end
   endtask

   // Fill the stores: exactly full, overflow on an insert, or stack full after a queue pop
   task automatic run_full_batch(input int variant);
      logic [KEY_W-1:0] first_key;
      logic [KEY_W-1:0] last_key;
      for (int n = 0; n < STORE_DEPTH; n++) begin
         last_key = $urandom;
         if (n == 0)
            first_key = last_key;
         send_op(OP_INSERT, last_key, variant == 0 && n == STORE_DEPTH - 1);
      end
      if (variant == 1) begin
         send_op(OP_INSERT, $urandom, 1'b0);
         send_op(OP_REMOVE, last_key, 1'b1);
      end else if (variant == 2) begin
         send_op(OP_REMOVE, first_key, 1'b0);
         send_op(OP_INSERT, $urandom, 1'b1);
      end
   endtask

   initial begin
      int batch_idx;
      int full_variant;
      int len;
      int pool;
      batch_idx    = 0;
      full_variant = 0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: lone insert, remove on empty, unknown operations
      send_op(OP_INSERT, 32'h8000_0000, 1'b1);
      send_op(OP_REMOVE, 32'h7FFF_FFFF, 1'b1);
      send_op(OP_ODD_LO, 32'h0000_0000, 1'b1);
      send_op(OP_ODD_HI, 32'hFFFF_FFFF, 1'b1);
      // stack-only order
      send_op(OP_INSERT, 32'h0000_0001, 1'b0);
      send_op(OP_INSERT, 32'h0000_0002, 1'b0);
      send_op(OP_REMOVE, 32'h0000_0002, 1'b0);
      send_op(OP_REMOVE, 32'h0000_0001, 1'b1);
      // queue-only order
      send_op(OP_INSERT, 32'hFFFF_FFFF, 1'b0);
      send_op(OP_INSERT, 32'h8000_0000, 1'b0);
      send_op(OP_REMOVE, 32'hFFFF_FFFF, 1'b0);
      send_op(OP_REMOVE, 32'h8000_0000, 1'b1);
      // both fit
      send_op(OP_INSERT, 32'h7FFF_FFFF, 1'b0);
      send_op(OP_REMOVE, 32'h7FFF_FFFF, 1'b1);
      // neither fits
      send_op(OP_INSERT, 32'h0000_0001, 1'b0);
      send_op(OP_INSERT, 32'h0000_0002, 1'b0);
      send_op(OP_REMOVE, 32'h0000_0003, 1'b1);
      // unknown operation inside a batch changes nothing
      send_op(OP_INSERT, 32'h0000_0000, 1'b0);
      send_op(OP_ODD_LO, 32'h0000_0005, 1'b0);
      send_op(OP_REMOVE, 32'h0000_0000, 1'b1);
      // remove past empty breaks both
      send_op(OP_INSERT, 32'h0000_0005, 1'b0);
      send_op(OP_REMOVE, 32'h0000_0005, 1'b0);
      send_op(OP_REMOVE, 32'h0000_0005, 1'b1);
      drain_verdicts();

      // Random batches, with a few full-store batches mixed in
      while (ops_sent < TARGET_OPS) begin
         batch_idx++;
         steady_flow = ($urandom_range(0, 5) == 0);
         if (batch_idx % 20 == 5 && full_variant < 3) begin
            run_full_batch(full_variant);
            full_variant++;
         end else begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(31, 90) : $urandom_range(1, 30);
            case ($urandom_range(0, 3))
               0:       pool = 0;
               1:       pool = 2;
               2:       pool = 4;
               default: pool = 8;
            endcase
            run_batch(len, remove_policy_type'($urandom_range(0, 2)), pool);
         end
         if ($urandom_range(0, 9) == 0)
            drain_verdicts();
      end
      steady_flow = 1'b0;

      drain_verdicts();
      repeat (12) @(posedge clock);
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
